// ===== hw/rtl/json_token_scanner_defines.svh =====
// Assertion helpers for the scanner RTL.
`ifndef JSON_TOKEN_SCANNER_DEFINES_SVH
`define JSON_TOKEN_SCANNER_DEFINES_SVH

// Condition that must hold at every clock edge outside reset.
`define JTS_HOLDS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Condition that must hold in the cycle after a trigger.
`define JTS_IMPLIES_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

// ===== hw/rtl/jts_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package jts_pkg;

  localparam int MAX_TOKENS = 64;
  localparam int MAX_TEXT   = 4096;
  localparam int ADDR_W     = $clog2(MAX_TOKENS);
  localparam int IDX_W      = ADDR_W + 1;
  localparam int POS_W      = $clog2(MAX_TEXT) + 1;

  localparam logic [IDX_W-1:0] NO_PARENT  = IDX_W'(MAX_TOKENS);
  localparam logic [IDX_W-1:0] TOKEN_MAX  = IDX_W'(MAX_TOKENS);
  localparam logic [POS_W-1:0] TEXT_LIMIT = POS_W'(MAX_TEXT);
  localparam logic [5:0]       CHILD_MAX  = 6'd63;

  localparam logic [2:0] KIND_NONE   = 3'd0;
  localparam logic [2:0] KIND_OBJECT = 3'd1;
  localparam logic [2:0] KIND_ARRAY  = 3'd2;
  localparam logic [2:0] KIND_STRING = 3'd3;
  localparam logic [2:0] KIND_PRIM   = 3'd4;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_TOKEN = 2'd1;
  localparam logic [1:0] ST_BAD_TEXT = 2'd2;
  localparam logic [1:0] ST_TOO_LONG = 2'd3;

  typedef struct packed {
    logic [2:0]       kind;
    logic [POS_W-1:0] first;
    logic [POS_W-1:0] stop;
    logic             closed;
    logic [5:0]       children;
    logic [IDX_W-1:0] parent;
  } entry_t;

  typedef struct packed {
    logic is_nul;
    logic is_open;
    logic is_close;
    logic is_brace;
    logic is_quote;
    logic is_bslash;
    logic is_space;
    logic is_colon;
    logic is_comma;
    logic is_esc;
    logic is_u;
    logic is_hex;
    logic is_delim;
    logic is_bad;
  } byte_class_t;

endpackage
`default_nettype wire

// ===== hw/rtl/jts_entry_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
module jts_entry_ram (
  input  logic                      clk,
  input  logic                      we,
  input  logic [jts_pkg::ADDR_W-1:0] waddr,
  input  jts_pkg::entry_t           wdata,
  input  logic [jts_pkg::ADDR_W-1:0] raddr,
  output jts_pkg::entry_t           rdata
);
  import jts_pkg::*;

  entry_t mem [MAX_TOKENS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== hw/rtl/jts_byte_class.sv =====
`timescale 1ns / 1ps
`default_nettype none
module jts_byte_class (
  input  logic [7:0]           text_byte,
  output jts_pkg::byte_class_t cls
);
  import jts_pkg::*;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_LBRK  = 8'h5B;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_RBRK  = 8'h5D;
  localparam logic [7:0] CH_LBRC  = 8'h7B;
  localparam logic [7:0] CH_RBRC  = 8'h7D;
  localparam logic [7:0] CH_DEL   = 8'd127;
  localparam logic [7:0] CH_D0    = 8'd48;
  localparam logic [7:0] CH_D9    = 8'd57;
  localparam logic [7:0] CH_UA    = 8'd65;
  localparam logic [7:0] CH_UF    = 8'd70;
  localparam logic [7:0] CH_LA    = 8'd97;
  localparam logic [7:0] CH_LF_HI = 8'd102;

  always_comb begin
    cls = '0;
    cls.is_nul    = (text_byte == 8'h00);
    cls.is_open   = (text_byte == CH_LBRC) || (text_byte == CH_LBRK);
    cls.is_close  = (text_byte == CH_RBRC) || (text_byte == CH_RBRK);
    cls.is_brace  = (text_byte == CH_LBRC) || (text_byte == CH_RBRC);
    cls.is_quote  = (text_byte == CH_QUOTE);
    cls.is_bslash = (text_byte == CH_BSL);
    cls.is_space  = (text_byte == CH_TAB) || (text_byte == CH_LF) ||
                    (text_byte == CH_CR) || (text_byte == CH_SP);
    cls.is_colon  = (text_byte == CH_COLON);
    cls.is_comma  = (text_byte == CH_COMMA);
    cls.is_esc    = (text_byte == CH_QUOTE) || (text_byte == CH_SLASH) ||
                    (text_byte == CH_BSL) || (text_byte == "b") ||
                    (text_byte == "f") || (text_byte == "r") ||
                    (text_byte == "n") || (text_byte == "t");
    cls.is_u      = (text_byte == "u");
    cls.is_hex    = ((text_byte >= CH_D0) && (text_byte <= CH_D9)) ||
                    ((text_byte >= CH_UA) && (text_byte <= CH_UF)) ||
                    ((text_byte >= CH_LA) && (text_byte <= CH_LF_HI));
    cls.is_delim  = cls.is_space || cls.is_comma || (text_byte == CH_RBRK) ||
                    (text_byte == CH_RBRC);
    cls.is_bad    = (text_byte < CH_SP) || (text_byte >= CH_DEL);
  end

endmodule
`default_nettype wire

// ===== hw/rtl/json_token_scanner.sv =====
`timescale 1ns / 1ps
`default_nettype none
// JSON token scanner. Feed the document one word per byte on text_byte, with
// end_of_text high on the last byte (or send a zero byte, which ends the
// document and is not counted as text). The token table lives in a single
// 64-entry synchronous RAM; every byte is handled by a small sequencer that
// reads, modifies and writes that RAM. Plain string and escape bytes need
// no RAM access; whitespace and a colon pass through the main state alone;
// an opening bracket, a string end or a comma also read or update the
// superior when one is set; a closing bracket reads the entries of the
// parent chain one by one; a byte that ends a primitive is handled as a
// string end and then as a delimiter, all through the one RAM read port. At
// the end of a document the table is read back one entry per word, each
// word held until it is taken; a failed or empty document gives a single word
// with token_valid low. Containers still open are reported with the
// end-of-text position. token_limit is written through its own channel,
// which is always ready; write it only while the scanner is idle. No new
// byte is taken while a result word waits on the output.
module json_token_scanner (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [7:0]                 text_byte,
  input  logic                       end_of_text,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [6:0]                 token_limit,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [1:0]                 status,
  output logic [6:0]                 token_count,
  output logic                       token_valid,
  output logic [2:0]                 token_kind,
  output logic [12:0]                token_first,
  output logic [12:0]                token_stop,
  output logic [5:0]                 child_count,
  output logic [6:0]                 parent_index,
  output logic                       last
);
  import jts_pkg::*;

`include "json_token_scanner_defines.svh"

  typedef enum logic [3:0] {
    S_IN, S_LEAF, S_CNT_RD, S_CNT_WR, S_MAIN, S_WALK_RD, S_WALK_CHK,
    S_SUP_RD, S_SUP_CHK, S_NEXT, S_FIN, S_OUT_RD, S_OUT_LOAD, S_OUT_HOLD
  } state_t;

  typedef enum logic [2:0] {
    M_IDLE, M_STRING, M_ESCAPE, M_HEX, M_PRIM
  } mode_t;

  state_t           state;
  mode_t            mode;
  logic [7:0]       byte_r;
  logic [POS_W-1:0] pos_r;
  logic             fin;
  logic             main_pend;
  logic [POS_W-1:0] text_position;
  logic [IDX_W-1:0] next_free;
  logic [IDX_W-1:0] cur_super;
  logic [2:0]       hex_left;
  logic [POS_W-1:0] pending_start;
  logic [1:0]       err;
  logic [6:0]       limit_r;
  logic [IDX_W-1:0] walk_n;
  logic [IDX_W-1:0] out_i;
  logic [2:0]       leaf_kind;
  logic [POS_W-1:0] leaf_first;
  logic [POS_W-1:0] leaf_stop;

  // RAM port signals
  logic              we;
  logic [ADDR_W-1:0] waddr;
  entry_t            wdata;
  logic [ADDR_W-1:0] raddr;
  entry_t            rdata;

  byte_class_t in_cls;
  byte_class_t cls;
  logic [6:0]  limit_eff;
  logic [2:0]  want_kind;
  logic [2:0]  hex_dec;
  logic        rd_open;

  jts_byte_class u_in_class (.text_byte(text_byte), .cls(in_cls));
  jts_byte_class u_held_class (.text_byte(byte_r), .cls(cls));

  jts_entry_ram u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign in_ready  = (state == S_IN);
  assign cfg_ready = 1'b1;
  assign limit_eff = (limit_r > TOKEN_MAX) ? TOKEN_MAX : limit_r;
  assign want_kind = cls.is_brace ? KIND_OBJECT : KIND_ARRAY;
  assign hex_dec   = (hex_left != 3'd0) ? hex_left - 3'd1 : 3'd0;
  assign rd_open   = !rdata.closed &&
                     ((rdata.kind == KIND_OBJECT) || (rdata.kind == KIND_ARRAY));

  // RAM writes: new entries go in at next_free; read-modify-write goes back
  // to the address just read. In a read-modify-write the read port stays on
  // that address, so one entry is read and written in the same cycle.
  always_comb begin
    we    = 1'b0;
    waddr = raddr;
    wdata = rdata;
    unique case (state)
      S_LEAF: begin
        we    = (next_free < limit_eff);
        waddr = next_free[ADDR_W-1:0];
        wdata = '{kind: leaf_kind, first: leaf_first, stop: leaf_stop,
                  closed: 1'b1, children: 6'd0, parent: cur_super};
      end
      S_MAIN: begin
        we    = cls.is_open && (next_free < limit_eff);
        waddr = next_free[ADDR_W-1:0];
        wdata = '{kind: (cls.is_brace ? KIND_OBJECT : KIND_ARRAY), first: pos_r,
                  stop: '0, closed: 1'b0, children: 6'd0, parent: cur_super};
      end
      S_CNT_WR: begin
        we = 1'b1;
        if (rdata.children < CHILD_MAX) begin
          wdata.children = rdata.children + 6'd1;
        end
      end
      S_WALK_CHK: begin
        we           = !rdata.closed && (rdata.kind == want_kind);
        wdata.stop   = pos_r + POS_W'(1);
        wdata.closed = 1'b1;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IN;
      mode          <= M_IDLE;
      fin           <= 1'b0;
      main_pend     <= 1'b0;
      text_position <= '0;
      next_free     <= '0;
      cur_super     <= NO_PARENT;
      hex_left      <= '0;
      pending_start <= '0;
      err           <= ST_OK;
      limit_r       <= 7'(MAX_TOKENS);
      out_valid     <= 1'b0;
      raddr         <= '0;
    end else begin
      if (cfg_valid) begin
        limit_r <= token_limit;
      end
      unique case (state)
        S_IN: begin
          if (in_valid) begin
            byte_r    <= text_byte;
            pos_r     <= text_position;
            fin       <= in_cls.is_nul || end_of_text;
            main_pend <= 1'b0;
            state     <= S_NEXT;
            if (!in_cls.is_nul && (text_position < TEXT_LIMIT)) begin
              text_position <= text_position + POS_W'(1);
            end
            if (!in_cls.is_nul && (err == ST_OK)) begin
              if (text_position >= TEXT_LIMIT) begin
                err <= ST_TOO_LONG;
              end else begin
                unique case (mode)
                  M_STRING: begin
                    if (in_cls.is_quote) begin
                      mode       <= M_IDLE;
                      leaf_kind  <= KIND_STRING;
                      leaf_first <= pending_start;
                      leaf_stop  <= text_position;
                      state      <= S_LEAF;
                    end else if (in_cls.is_bslash) begin
                      mode <= M_ESCAPE;
                    end
                  end
                  M_ESCAPE: begin
                    if (in_cls.is_esc) begin
                      mode <= M_STRING;
                    end else if (in_cls.is_u) begin
                      hex_left <= 3'd4;
                      mode     <= M_HEX;
                    end else begin
                      err <= ST_BAD_TEXT;
                    end
                  end
                  M_HEX: begin
                    if (!in_cls.is_hex) begin
                      err <= ST_BAD_TEXT;
                    end else begin
                      hex_left <= hex_dec;
                      if (hex_dec == 3'd0) begin
                        mode <= M_STRING;
                      end
                    end
                  end
                  M_PRIM: begin
                    if (in_cls.is_delim) begin
                      mode       <= M_IDLE;
                      leaf_kind  <= KIND_PRIM;
                      leaf_first <= pending_start;
                      leaf_stop  <= text_position;
                      main_pend  <= 1'b1;
                      state      <= S_LEAF;
                    end else if (in_cls.is_bad) begin
                      err <= ST_BAD_TEXT;
                    end
                  end
                  default: begin
                    state <= S_MAIN;
                  end
                endcase
              end
            end
          end
        end
        S_LEAF: begin
          // allocate, then count the child on the current superior
          if (next_free >= limit_eff) begin
            err   <= ST_NO_TOKEN;
            state <= S_NEXT;
          end else begin
            next_free <= next_free + IDX_W'(1);
            raddr     <= cur_super[ADDR_W-1:0];
            state     <= (cur_super != NO_PARENT) ? S_CNT_RD : S_NEXT;
          end
        end
        S_CNT_RD: begin
          state <= S_CNT_WR;
        end
        S_CNT_WR: begin
          state <= S_NEXT;
        end
        S_MAIN: begin
          state <= S_NEXT;
          if (cls.is_open) begin
            if (next_free >= limit_eff) begin
              err <= ST_NO_TOKEN;
            end else begin
              next_free <= next_free + IDX_W'(1);
              raddr     <= cur_super[ADDR_W-1:0];
              cur_super <= next_free;
              if (cur_super != NO_PARENT) begin
                state <= S_CNT_RD;
              end
            end
          end else if (cls.is_close) begin
            if (next_free == '0) begin
              err <= ST_BAD_TEXT;
            end else begin
              raddr  <= ADDR_W'(next_free - IDX_W'(1));
              walk_n <= '0;
              state  <= S_WALK_RD;
            end
          end else if (cls.is_quote) begin
            pending_start <= pos_r + POS_W'(1);
            mode          <= M_STRING;
          end else if (cls.is_space) begin
            mode <= M_IDLE;
          end else if (cls.is_colon) begin
            cur_super <= (next_free == '0) ? NO_PARENT : next_free - IDX_W'(1);
          end else if (cls.is_comma) begin
            if (cur_super < next_free) begin
              raddr <= cur_super[ADDR_W-1:0];
              state <= S_SUP_RD;
            end
          end else if (cls.is_bad) begin
            err <= ST_BAD_TEXT;
          end else begin
            pending_start <= pos_r;
            mode          <= M_PRIM;
          end
        end
        S_WALK_RD: begin
          state <= S_WALK_CHK;
        end
        S_WALK_CHK: begin
          // walk up towards the innermost open container
          state <= S_NEXT;
          if (!rdata.closed) begin
            if (rdata.kind != want_kind) begin
              err <= ST_BAD_TEXT;
            end else begin
              cur_super <= rdata.parent;
            end
          end else if (rdata.parent == NO_PARENT) begin
            if ((rdata.kind != want_kind) || (cur_super == NO_PARENT)) begin
              err <= ST_BAD_TEXT;
            end
          end else if ((walk_n == TOKEN_MAX) || (rdata.parent >= next_free)) begin
            err <= ST_BAD_TEXT;
          end else begin
            walk_n <= walk_n + IDX_W'(1);
            raddr  <= rdata.parent[ADDR_W-1:0];
            state  <= S_WALK_RD;
          end
        end
        S_SUP_RD: begin
          state <= S_SUP_CHK;
        end
        S_SUP_CHK: begin
          if ((rdata.kind != KIND_ARRAY) && (rdata.kind != KIND_OBJECT)) begin
            cur_super <= rdata.parent;
          end
          state <= S_NEXT;
        end
        S_NEXT: begin
          main_pend <= 1'b0;
          if (main_pend && (err == ST_OK)) begin
            state <= S_MAIN;
          end else if (fin) begin
            state <= S_FIN;
          end else begin
            state <= S_IN;
          end
        end
        S_FIN: begin
          // close an open primitive, flag unfinished strings, then read out
          if ((err == ST_OK) && (mode == M_PRIM)) begin
            mode       <= M_IDLE;
            leaf_kind  <= KIND_PRIM;
            leaf_first <= pending_start;
            leaf_stop  <= text_position;
            state      <= S_LEAF;
          end else if ((err == ST_OK) && (mode != M_IDLE)) begin
            err <= ST_BAD_TEXT;
          end else begin
            out_i <= '0;
            raddr <= '0;
            state <= S_OUT_RD;
          end
        end
        S_OUT_RD: begin
          state <= S_OUT_LOAD;
        end
        S_OUT_LOAD: begin
          status      <= err;
          token_count <= (err == ST_OK) ? next_free : '0;
          out_valid   <= 1'b1;
          state       <= S_OUT_HOLD;
          if ((err == ST_OK) && (next_free != '0)) begin
            token_valid  <= 1'b1;
            token_kind   <= rdata.kind;
            token_first  <= rdata.first;
            token_stop   <= rd_open ? text_position : rdata.stop;
            child_count  <= rdata.children;
            parent_index <= rdata.parent;
            last         <= (out_i + IDX_W'(1) == next_free);
          end else begin
            token_valid  <= 1'b0;
            token_kind   <= KIND_NONE;
            token_first  <= '0;
            token_stop   <= '0;
            child_count  <= '0;
            parent_index <= '0;
            last         <= 1'b1;
          end
        end
        S_OUT_HOLD: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            if (last) begin
              // drop back to a clean parse state for the next document
              mode          <= M_IDLE;
              fin           <= 1'b0;
              text_position <= '0;
              next_free     <= '0;
              cur_super     <= NO_PARENT;
              hex_left      <= '0;
              pending_start <= '0;
              err           <= ST_OK;
              state         <= S_IN;
            end else begin
              out_i <= out_i + IDX_W'(1);
              raddr <= ADDR_W'(out_i + IDX_W'(1));
              state <= S_OUT_RD;
            end
          end
        end
        default: begin
          state <= S_IN;
        end
      endcase
    end
  end

  `JTS_HOLDS(a_one_side, !(in_ready && out_valid), "byte taken while a result word waits")
  `JTS_HOLDS(a_fill, next_free <= TOKEN_MAX, "token table overfilled")
  `JTS_HOLDS(a_pos, text_position <= TEXT_LIMIT, "text position past its saturation")
  `JTS_IMPLIES_NEXT(a_doc_reset, out_valid && out_ready && last, (next_free == '0) && (cur_super == NO_PARENT) && (text_position == '0), "parse state not cleared after document")

endmodule
`default_nettype wire
